FILE: rtl/core/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg
// Shared types and constants for the tour length evaluator.
// ----------------------------------------------------------------------------
package tle_pkg;

    localparam int IDX_BITS       = 10;
    localparam int SUM_BITS       = 48;
    localparam int DEF_MAX_CITIES = 1024;
    localparam int DEF_COORD_BITS = 24;
    localparam int FIFO_DEPTH     = 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_VISIT = 1'b1;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_GAP,
        BK_SQUARE,
        BK_ADD,
        BK_ROOT,
        BK_ACC
    } bk_state_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

endpackage

FILE: rtl/core/tle_ram.sv
// ----------------------------------------------------------------------------
// tle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/tle_fifo.sv
// ----------------------------------------------------------------------------
// tle_fifo
// Short queue between the lookup front and the distance back end.
// ----------------------------------------------------------------------------
module tle_fifo
    import tle_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output fifo_stat_t       stat
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [FIFO_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data   = slot_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(FIFO_DEPTH));

endmodule

FILE: rtl/core/tle_front.sv
// ----------------------------------------------------------------------------
// tle_front
// Accepts items, writes the city table, looks up visited cities and queues
// their coordinates for the back end.
// ----------------------------------------------------------------------------
module tle_front
    import tle_pkg::*;
#(
    parameter int MAX_CITIES = DEF_MAX_CITIES,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_cmd,
    input  logic [IDX_BITS-1:0]           in_idx,
    input  logic [COORD_BITS-1:0]         in_x,
    input  logic [COORD_BITS-1:0]         in_y,
    input  logic                          in_last,
    output logic                          ram_we,
    output logic [$clog2(MAX_CITIES)-1:0] ram_waddr,
    output logic [2*COORD_BITS-1:0]       ram_wdata,
    output logic                          ram_re,
    output logic [$clog2(MAX_CITIES)-1:0] ram_raddr,
    input  logic [2*COORD_BITS-1:0]       ram_rdata,
    input  fifo_stat_t                    q_stat,
    output logic                          q_push,
    output logic [2*COORD_BITS:0]         q_data
);

    localparam int AW = $clog2(MAX_CITIES);

    logic [31:0]   idx_ext;
    logic          in_range;
    logic          accept;
    logic          pend_reg;
    logic          pend_last_reg;
    logic          pend_inr_reg;

    assign idx_ext  = {{(32 - IDX_BITS){1'b0}}, in_idx};
    assign in_range = (idx_ext < 32'(MAX_CITIES));
    assign in_ready = q_stat.empty || (!q_stat.full && !pend_reg);
    assign accept   = in_valid && in_ready;

    assign ram_we    = accept && (in_cmd == CMD_WRITE) && in_range;
    assign ram_waddr = idx_ext[AW-1:0];
    assign ram_wdata = {in_y, in_x};
    assign ram_re    = accept && (in_cmd == CMD_VISIT);
    assign ram_raddr = idx_ext[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= ram_re;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            pend_last_reg <= in_last;
            pend_inr_reg  <= in_range;
        end
    end

    // out-of-range visit reads as the origin
    assign q_push = pend_reg;
    assign q_data = {pend_last_reg, pend_inr_reg ? ram_rdata : {(2*COORD_BITS){1'b0}}};

endmodule

FILE: rtl/core/tle_back.sv
// ----------------------------------------------------------------------------
// tle_back
// Tour sequencer: edge gap, squares, bit-serial square root, saturating sum
// and the result register.
// ----------------------------------------------------------------------------
module tle_back
    import tle_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fifo_stat_t            q_stat,
    input  logic [2*COORD_BITS:0] q_data,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SUM_BITS-1:0]   m_tdata,
    output logic                  m_tuser
);

    localparam int CB   = COORD_BITS;
    localparam int CNTW = $clog2(CB + 1);

    bk_state_t state_reg, state_next;

    logic [CB-1:0]       cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [CB-1:0]       op_x_reg, op_x_next, op_y_reg, op_y_next;
    logic [CB-1:0]       start_x_reg, start_x_next, start_y_reg, start_y_next;
    logic [CB-1:0]       prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic [CB-1:0]       dx_reg, dx_next, dy_reg, dy_next;
    logic [2*CB-1:0]     sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [2*CB+1:0]     rad_reg, rad_next;
    logic [CB+2:0]       rem_reg, rem_next;
    logic [CB:0]         root_reg, root_next;
    logic [CNTW-1:0]     cnt_reg, cnt_next;
    logic [SUM_BITS-1:0] sum_reg, sum_next;
    logic                last_reg, last_next;
    logic                closing_reg, closing_next;
    logic                active_reg, active_next;
    logic                sat_reg, sat_next;
    logic                mval_reg, mval_next;
    logic [SUM_BITS-1:0] mdata_reg, mdata_next;
    logic                muser_reg, muser_next;

    logic [CB-1:0]       q_x, q_y;
    logic                q_last;
    logic [CB:0]         diff_x, diff_y;
    logic [CB+2:0]       shifted, trial;
    logic [SUM_BITS:0]   acc_raw;
    logic [SUM_BITS-1:0] acc_sum;
    logic                acc_sat;
    logic                out_free;

    assign q_x    = q_data[CB-1:0];
    assign q_y    = q_data[2*CB-1:CB];
    assign q_last = q_data[2*CB];

    assign diff_x  = {cur_x_reg[CB-1], cur_x_reg} - {op_x_reg[CB-1], op_x_reg};
    assign diff_y  = {cur_y_reg[CB-1], cur_y_reg} - {op_y_reg[CB-1], op_y_reg};
    assign shifted = {rem_reg[CB:0], rad_reg[2*CB+1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign acc_raw = {1'b0, sum_reg} + (SUM_BITS+1)'(root_reg);
    assign acc_sat = acc_raw[SUM_BITS];
    assign acc_sum = acc_sat ? {SUM_BITS{1'b1}} : acc_raw[SUM_BITS-1:0];
    assign out_free = !mval_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        op_x_next    = op_x_reg;
        op_y_next    = op_y_reg;
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        sqx_next     = sqx_reg;
        sqy_next     = sqy_reg;
        rad_next     = rad_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        last_next    = last_reg;
        closing_next = closing_reg;
        active_next  = active_reg;
        sat_next     = sat_reg;
        mval_next    = mval_reg && !m_tready;
        mdata_next   = mdata_reg;
        muser_next   = muser_reg;
        q_pop        = 1'b0;

        unique case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop       = 1'b1;
                    cur_x_next  = q_x;
                    cur_y_next  = q_y;
                    last_next   = q_last;
                    prev_x_next = q_x;
                    prev_y_next = q_y;
                    if (!active_reg) begin
                        start_x_next = q_x;
                        start_y_next = q_y;
                        sum_next     = '0;
                        sat_next     = 1'b0;
                        active_next  = 1'b1;
                        op_x_next    = q_x;
                        op_y_next    = q_y;
                        closing_next = 1'b1;
                        if (q_last) begin
                            state_next = BK_GAP;
                        end
                    end else begin
                        op_x_next    = prev_x_reg;
                        op_y_next    = prev_y_reg;
                        closing_next = 1'b0;
                        state_next   = BK_GAP;
                    end
                end
            end
            BK_GAP: begin
                dx_next    = diff_x[CB] ? CB'(-diff_x) : diff_x[CB-1:0];
                dy_next    = diff_y[CB] ? CB'(-diff_y) : diff_y[CB-1:0];
                state_next = BK_SQUARE;
            end
            BK_SQUARE: begin
                sqx_next   = dx_reg * dx_reg;
                sqy_next   = dy_reg * dy_reg;
                state_next = BK_ADD;
            end
            BK_ADD: begin
                rad_next   = {1'b0, {1'b0, sqx_reg} + {1'b0, sqy_reg}};
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = CNTW'(CB);
                state_next = BK_ROOT;
            end
            BK_ROOT: begin
                rad_next = {rad_reg[2*CB-1:0], 2'b00};
                if (shifted >= trial) begin
                    rem_next  = shifted - trial;
                    root_next = {root_reg[CB-1:0], 1'b1};
                end else begin
                    rem_next  = shifted;
                    root_next = {root_reg[CB-1:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = BK_ACC;
                end
            end
            BK_ACC: begin
                if (!closing_reg) begin
                    sum_next = acc_sum;
                    sat_next = sat_reg || acc_sat;
                    if (last_reg) begin
                        op_x_next    = start_x_reg;
                        op_y_next    = start_y_reg;
                        closing_next = 1'b1;
                        state_next   = BK_GAP;
                    end else begin
                        state_next = BK_IDLE;
                    end
                end else if (out_free) begin
                    sum_next    = acc_sum;
                    sat_next    = sat_reg || acc_sat;
                    mval_next   = 1'b1;
                    mdata_next  = acc_sum;
                    muser_next  = sat_reg || acc_sat;
                    active_next = 1'b0;
                    state_next  = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            active_reg  <= 1'b0;
            sat_reg     <= 1'b0;
            sum_reg     <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            mval_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            sat_reg     <= sat_next;
            sum_reg     <= sum_next;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            prev_x_reg  <= prev_x_next;
            prev_y_reg  <= prev_y_next;
            mval_reg    <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        op_x_reg    <= op_x_next;
        op_y_reg    <= op_y_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        sqx_reg     <= sqx_next;
        sqy_reg     <= sqy_next;
        rad_reg     <= rad_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        cnt_reg     <= cnt_next;
        last_reg    <= last_next;
        closing_reg <= closing_next;
        mdata_reg   <= mdata_next;
        muser_reg   <= muser_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule

FILE: rtl/core/tour_length_evaluator.sv
// ----------------------------------------------------------------------------
// tour_length_evaluator
// Closed-tour Euclidean length over a table of Q16.8 city coordinates.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser = command (0 write city, 1 visit city), tlast marks
// the final visit of a tour, tdata = city index, x, y. A write stores x/y at
// the index; a visit looks the city up and adds the edge from the previous
// city. The last visit also adds the closing edge and emits one item on m_*:
// tdata = total length (Q40.8, saturating), tuser = overflow flag.
// Each edge passes the back end in steps (gap, square, sum of squares, one root
// bit per cycle, accumulate). Every visit is popped from the queue; each but
// the first of a tour adds one edge, and the last also adds the closing edge.
// Writes stay in the front end. The city table lookup is registered ahead of a
// two-entry queue, so writes and lookups proceed while the back end works.
// Reset empties the queue, closes any open tour and drops a pending result; the
// table contents stay undefined until written. A stalled m_tready holds the
// result; the back end then waits only when it has the next result ready, and
// s_tready falls once the queue fills.
// ----------------------------------------------------------------------------
module tour_length_evaluator
    import tle_pkg::*;
#(
    parameter int MAX_CITIES = DEF_MAX_CITIES,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // city_index, x_coord, y_coord, zero pad
    input  logic [((IDX_BITS+2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // command
    input  logic                                        s_tuser,
    input  logic                                        s_tlast,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // total_distance
    output logic [SUM_BITS-1:0]                         m_tdata,
    // overflowed
    output logic                                        m_tuser
);

    localparam int AW = $clog2(MAX_CITIES);
    localparam int CB = COORD_BITS;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [2*CB-1:0]     ram_wdata, ram_rdata;
    fifo_stat_t          q_stat;
    logic                q_push, q_pop;
    logic [2*CB:0]       q_in, q_out;

    tle_front #(
        .MAX_CITIES (MAX_CITIES),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_idx    (s_tdata[IDX_BITS-1:0]),
        .in_x      (s_tdata[IDX_BITS+CB-1:IDX_BITS]),
        .in_y      (s_tdata[IDX_BITS+2*CB-1:IDX_BITS+CB]),
        .in_last   (s_tlast),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    tle_ram #(
        .WIDTH (2*CB),
        .DEPTH (MAX_CITIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tle_fifo #(
        .WIDTH (2*CB+1)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    tle_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: rtl/core/tle_checker.sv
// ----------------------------------------------------------------------------
// tle_checker
// Port-level checks on the result channel of the tour length evaluator.
// ----------------------------------------------------------------------------
module tle_checker
    import tle_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [SUM_BITS-1:0] m_tdata,
    input logic                m_tuser
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // reset drops any pending result
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // overflow flag only with a saturated total
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == {SUM_BITS{1'b1}})
        else $error("overflow flagged below saturation");

endmodule

bind tour_length_evaluator tle_checker u_tle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
